### sv/wpf_pkg.sv
// Shared constants for the windowed peak finder.
// No dependencies; compile first.
package wpf_pkg;

  localparam int unsigned MAX_HALF_WIDTH = 31;
  localparam int unsigned SAMPLE_BITS    = 16;
  localparam int unsigned INDEX_BITS     = 24;
  localparam int unsigned CFG_BITS       = 5;

  localparam logic [CFG_BITS-1:0] HALF_WIDTH_RST = CFG_BITS'(1);

endpackage

### sv/wpf_in_if.sv
// Sample request channel of the windowed peak finder: valid, ready, one sample and record_end.
// Depends on wpf_pkg for the default sample width.
interface wpf_in_if #(
  parameter int unsigned SAMPLE_BITS = wpf_pkg::SAMPLE_BITS
);

  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_value;
  logic                          record_end;

  modport source (output valid, output sample_value, output record_end, input ready);
  modport sink   (input valid, input sample_value, input record_end, output ready);

endinterface

### sv/wpf_out_if.sv
// Result request channel of the windowed peak finder: valid, ready and one result.
// Depends on wpf_pkg for the default index width.
interface wpf_out_if #(
  parameter int unsigned INDEX_BITS = wpf_pkg::INDEX_BITS
);

  logic                  valid;
  logic                  ready;
  logic [INDEX_BITS-1:0] peak_index;
  logic                  found;
  logic                  final_res;

  modport source (output valid, output peak_index, output found, output final_res,
                  input ready);
  modport sink   (input valid, input peak_index, input found, input final_res,
                  output ready);

endinterface

### sv/wpf_cell.sv
// One window cell: holds a sample, its valid bit and the distances to the nearest
// older and newer samples that are not smaller. Standalone; used by windowed_peak_finder.
module wpf_cell #(
  parameter int unsigned MAX_HALF_WIDTH = 31,
  parameter int unsigned SAMPLE_BITS    = 16,
  parameter int unsigned POST_DEPTH     = 1
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic load_i,
  input  logic clear_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic [SAMPLE_BITS+2*$clog2(MAX_HALF_WIDTH+2):0] cell_i,
  output logic [SAMPLE_BITS+2*$clog2(MAX_HALF_WIDTH+2):0] cell_o,
  output logic ge_o
);

  localparam int unsigned DIST_BITS = $clog2(MAX_HALF_WIDTH + 2);
  localparam logic [DIST_BITS-1:0] DIST_NONE = DIST_BITS'(MAX_HALF_WIDTH + 1);

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          valid;
    logic [DIST_BITS-1:0]          older;
    logic [DIST_BITS-1:0]          newer;
  } cell_t;

  cell_t prev;
  cell_t upd;
  logic                          valid_q;
  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic [DIST_BITS-1:0]          older_q;
  logic [DIST_BITS-1:0]          newer_q;

  assign prev = cell_t'(cell_i);

  always_comb begin
    upd.sample = sample_q;
    upd.valid  = valid_q;
    upd.older  = older_q;
    upd.newer  = newer_q;
    if (valid_q && (newer_q == DIST_NONE) && (sample_i >= sample_q)) begin
      upd.newer = DIST_BITS'(POST_DEPTH);
    end
  end

  assign cell_o = upd;
  assign ge_o   = valid_q && (sample_q >= sample_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= prev.valid && !clear_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      sample_q <= prev.sample;
      older_q  <= prev.older;
      newer_q  <= prev.newer;
    end
  end

endmodule

### sv/wpf_out_buf.sv
// Two-entry result buffer that drives the result channel.
// Depends on wpf_out_if; used by windowed_peak_finder.
module wpf_out_buf #(
  parameter int unsigned INDEX_BITS = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  logic [INDEX_BITS-1:0] peak_index_i,
  input  logic                  found_i,
  input  logic                  final_res_i,
  output logic                  full_o,
  wpf_out_if.source             res_o
);

  typedef struct packed {
    logic [INDEX_BITS-1:0] peak_index;
    logic                  found;
    logic                  final_res;
  } res_t;

  res_t       slot_q [2];
  logic       wp_q;
  logic       rp_q;
  logic [1:0] cnt_q;
  logic [1:0] cnt_d;
  logic       pop;

  assign full_o           = (cnt_q == 2'd2);
  assign res_o.valid      = (cnt_q != 2'd0);
  assign res_o.peak_index = slot_q[rp_q].peak_index;
  assign res_o.found      = slot_q[rp_q].found;
  assign res_o.final_res  = slot_q[rp_q].final_res;
  assign pop              = res_o.valid && res_o.ready;

  always_comb begin
    case ({push_i, pop})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wp_q <= !wp_q;
      end
      if (pop) begin
        rp_q <= !rp_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wp_q] <= '{peak_index: peak_index_i, found: found_i, final_res: final_res_i};
    end
  end

endmodule

### sv/windowed_peak_finder.sv
// Windowed peak finder top level: a row of window cells, the peak decision and the
// result buffer. Depends on wpf_pkg, wpf_in_if, wpf_out_if, wpf_cell, wpf_out_buf.
//
// Usage:
//   smp_i carries one sample request per item; record_end marks the last sample of a
//   record. res_o carries results: a peak index with found set, and on the last sample
//   of a record one result with final_res set (found clear if no peak remains).
//   half_width is written through cfg_we_i / cfg_wdata_i; the user must write it only
//   while the block is idle, which the block does not enforce. 0 acts as 1 and values
//   above MAX_HALF_WIDTH act as MAX_HALF_WIDTH. Throughput: one sample per cycle while
//   smp_i.ready is high. Every sample compares against all cells in the cycle it is
//   taken, so the cell row sets that rate. A result is written into the result buffer
//   when the sample that decides it is taken; a peak is decided when the sample
//   half_width positions after it arrives. A two-entry result buffer sits between the
//   cell row and res_o. When the receiver stalls, samples are still taken until both
//   entries hold results; then smp_i.ready drops until one is taken.
//   Reset: all cells invalid, position counter zero, half_width back to 1; the block
//   takes samples in the first cycle after reset.
module windowed_peak_finder #(
  parameter int unsigned MAX_HALF_WIDTH = wpf_pkg::MAX_HALF_WIDTH,
  parameter int unsigned SAMPLE_BITS    = wpf_pkg::SAMPLE_BITS,
  parameter int unsigned INDEX_BITS     = wpf_pkg::INDEX_BITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [wpf_pkg::CFG_BITS-1:0] cfg_wdata_i,
  wpf_in_if.sink                       smp_i,
  wpf_out_if.source                    res_o
);

  localparam int unsigned DIST_BITS = $clog2(MAX_HALF_WIDTH + 2);
  localparam int unsigned HW_BITS   = (MAX_HALF_WIDTH > 1) ? $clog2(MAX_HALF_WIDTH + 1) : 1;
  localparam int unsigned CELL_BITS = SAMPLE_BITS + 1 + 2 * DIST_BITS;
  localparam logic [DIST_BITS-1:0]  DIST_NONE = DIST_BITS'(MAX_HALF_WIDTH + 1);
  localparam logic [INDEX_BITS-1:0] POS_MAX   = '1;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          valid;
    logic [DIST_BITS-1:0]          older;
    logic [DIST_BITS-1:0]          newer;
  } cell_t;

  logic [wpf_pkg::CFG_BITS-1:0] half_width_q;
  logic [INDEX_BITS-1:0]        pos_q;
  logic [INDEX_BITS-1:0]        pos_d;

  logic                          accept;
  logic                          rec_end;
  logic signed [SAMPLE_BITS-1:0] x;
  logic [HW_BITS-1:0]            h_eff;
  logic [DIST_BITS-1:0]          h_dist;
  logic [DIST_BITS-1:0]          new_older;
  cell_t                         new_cell;
  logic [CELL_BITS-1:0]          cell_in  [MAX_HALF_WIDTH];
  cell_t                         upd      [MAX_HALF_WIDTH];
  logic [CELL_BITS-1:0]          upd_raw  [MAX_HALF_WIDTH];
  logic [MAX_HALF_WIDTH-1:0]     ge;
  logic [MAX_HALF_WIDTH:0]       pk;
  logic                          end_found;
  logic [HW_BITS-1:0]            end_d;
  logic [HW_BITS-1:0]            pick_d;
  logic [INDEX_BITS-1:0]         pick_ext;
  logic [INDEX_BITS-1:0]         idx;
  logic                          fire;
  logic                          res_found;
  logic                          full;

  assign accept  = smp_i.valid && smp_i.ready;
  assign rec_end = smp_i.record_end;
  assign x       = smp_i.sample_value;
  assign smp_i.ready = !full;

  always_comb begin
    if (half_width_q == '0) begin
      h_eff = HW_BITS'(1);
    end else if (32'(half_width_q) > 32'(MAX_HALF_WIDTH)) begin
      h_eff = HW_BITS'(MAX_HALF_WIDTH);
    end else begin
      h_eff = HW_BITS'(half_width_q);
    end
  end

  assign h_dist = DIST_BITS'(h_eff);

  always_comb begin
    new_older = DIST_NONE;
    for (int k = MAX_HALF_WIDTH - 1; k >= 0; k--) begin
      if (ge[k]) begin
        new_older = DIST_BITS'(k + 1);
      end
    end
  end

  assign new_cell = '{sample: x, valid: 1'b1, older: new_older, newer: DIST_NONE};

  for (genvar k = 0; k < MAX_HALF_WIDTH; k++) begin : g_cell
    if (k == 0) begin : g_head
      assign cell_in[k] = new_cell;
    end else begin : g_link
      assign cell_in[k] = upd_raw[k-1];
    end

    wpf_cell #(
      .MAX_HALF_WIDTH (MAX_HALF_WIDTH),
      .SAMPLE_BITS    (SAMPLE_BITS),
      .POST_DEPTH     (k + 1)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .load_i   (accept),
      .clear_i  (rec_end),
      .sample_i (x),
      .cell_i   (cell_in[k]),
      .cell_o   (upd_raw[k]),
      .ge_o     (ge[k])
    );

    assign upd[k]  = cell_t'(upd_raw[k]);
    assign pk[k+1] = upd[k].valid && (upd[k].older > h_dist) && (upd[k].newer > h_dist);
  end

  assign pk[0] = (new_older > h_dist);

  always_comb begin
    end_found = 1'b0;
    end_d     = '0;
    for (int d = 0; d <= MAX_HALF_WIDTH; d++) begin
      if (pk[d] && (d <= int'(h_eff))) begin
        end_found = 1'b1;
        end_d     = HW_BITS'(d);
      end
    end
  end

  assign pick_d    = rec_end ? end_d : h_eff;
  assign pick_ext  = INDEX_BITS'(pick_d);
  assign fire      = rec_end || pk[h_eff];
  assign res_found = rec_end ? end_found : 1'b1;
  assign idx       = (pos_q < pick_ext) ? '0 : (pos_q - pick_ext);

  always_comb begin
    pos_d = pos_q;
    if (rec_end) begin
      pos_d = '0;
    end else if (pos_q != POS_MAX) begin
      pos_d = pos_q + INDEX_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_width_q <= wpf_pkg::HALF_WIDTH_RST;
      pos_q        <= '0;
    end else begin
      if (cfg_we_i) begin
        half_width_q <= cfg_wdata_i;
      end
      if (accept) begin
        pos_q <= pos_d;
      end
    end
  end

  wpf_out_buf #(
    .INDEX_BITS (INDEX_BITS)
  ) u_out_buf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (accept && fire),
    .peak_index_i (res_found ? idx : '0),
    .found_i      (res_found),
    .final_res_i  (rec_end),
    .full_o       (full),
    .res_o        (res_o)
  );

endmodule

### sv/wpf_checker.sv
// Port-level checks of the windowed peak finder and the bind that attaches them.
// Depends on windowed_peak_finder; compile after the top level.
module wpf_checker #(
  parameter int unsigned INDEX_BITS = 24
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_i,
  input logic                  in_end_i,
  input logic                  out_valid_i,
  input logic                  out_ready_i,
  input logic                  out_found_i,
  input logic                  out_final_i,
  input logic [INDEX_BITS-1:0] out_index_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result request dropped while stalled");

  a_empty_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_found_i |-> out_final_i && (out_index_i == '0))
    else $error("result without peak is not a clean end marker");

  a_end_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_end_i && !out_valid_i |=> out_valid_i && out_final_i)
    else $error("record end did not produce a final result");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i)
    else $error("sample request stalled with no result waiting");

endmodule

bind windowed_peak_finder wpf_checker #(
  .INDEX_BITS (INDEX_BITS)
) u_wpf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (smp_i.valid),
  .in_ready_i  (smp_i.ready),
  .in_end_i    (smp_i.record_end),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .out_found_i (res_o.found),
  .out_final_i (res_o.final_res),
  .out_index_i (res_o.peak_index)
);

### test/windowed_peak_finder_chk.sv
`timescale 1ns / 100ps
// Checker for windowed_peak_finder: follows the half_width register, predicts peak results
// from accepted sample requests and compares them with accepted result requests.
// Depends on wpf_pkg, wpf_in_if and wpf_out_if.
module windowed_peak_finder_chk (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [wpf_pkg::CFG_BITS-1:0] cfg_wdata_i,
  wpf_in_if                            smp_i,
  wpf_out_if                           res_i,
  output int                           err_cnt_o,
  output int                           pending_o
);

  localparam int WIN_DEPTH  = 2 * int'(wpf_pkg::MAX_HALF_WIDTH) + 1;
  localparam int MAX_REPORT = 10;

  typedef struct packed {
    logic [wpf_pkg::INDEX_BITS-1:0] index;
    logic                           found;
    logic                           last;
  } peak_res_t;

  logic signed [wpf_pkg::SAMPLE_BITS-1:0] win_q   [WIN_DEPTH];
  logic                                   win_vld [WIN_DEPTH];
  logic [wpf_pkg::INDEX_BITS-1:0]         pos_q;
  logic [wpf_pkg::CFG_BITS-1:0]           hw_q;
  peak_res_t                              peaks_due [$];
  int                                     errs;

  function automatic int eff_half_width(logic [wpf_pkg::CFG_BITS-1:0] v);
    if (v == '0) return 1;
    if (int'(v) > int'(wpf_pkg::MAX_HALF_WIDTH)) return int'(wpf_pkg::MAX_HALF_WIDTH);
    return int'(v);
  endfunction

  function automatic logic is_peak(int d, int h);
    if (!win_vld[d]) return 1'b0;
    for (int k = 1; k <= h; k++) begin
      if (d - k >= 0 && win_vld[d-k] && win_q[d-k] >= win_q[d]) return 1'b0;
      if (d + k < WIN_DEPTH && win_vld[d+k] && win_q[d+k] >= win_q[d]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic [wpf_pkg::INDEX_BITS-1:0] peak_pos(
    logic [wpf_pkg::INDEX_BITS-1:0] p, int d);
    if (int'(p) < d) return '0;
    return p - wpf_pkg::INDEX_BITS'(d);
  endfunction

  task automatic take_sample(logic signed [wpf_pkg::SAMPLE_BITS-1:0] v, logic last);
    int        h;
    peak_res_t r;
    logic      hit;
    h = eff_half_width(hw_q);
    for (int i = WIN_DEPTH - 1; i > 0; i--) begin
      win_q[i]   = win_q[i-1];
      win_vld[i] = win_vld[i-1];
    end
    win_q[0]   = v;
    win_vld[0] = 1'b1;
    r.index = '0;
    r.found = 1'b0;
    r.last  = last;
    if (!last) begin
      if (is_peak(h, h)) begin
        r.index = peak_pos(pos_q, h);
        r.found = 1'b1;
        peaks_due.push_back(r);
      end
      if (pos_q != '1) pos_q++;
    end else begin
      hit = 1'b0;
      for (int d = h; d >= 0 && !hit; d--) begin
        if (is_peak(d, h)) begin
          r.index = peak_pos(pos_q, d);
          r.found = 1'b1;
          hit     = 1'b1;
        end
      end
      peaks_due.push_back(r);
      for (int i = 0; i < WIN_DEPTH; i++) win_vld[i] = 1'b0;
      pos_q = '0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    peak_res_t want;
    if (!rst_ni) begin
      for (int i = 0; i < WIN_DEPTH; i++) begin
        win_q[i]   = '0;
        win_vld[i] = 1'b0;
      end
      pos_q = '0;
      hw_q  = wpf_pkg::HALF_WIDTH_RST;
      errs  = 0;
      peaks_due.delete();
      err_cnt_o <= 0;
      pending_o <= 0;
    end else begin
      if (res_i.valid && res_i.ready) begin
        if (peaks_due.size() == 0) begin
          errs++;
          if (errs <= MAX_REPORT)
            $display("unexpected result: index %0d found %0b final %0b",
                     res_i.peak_index, res_i.found, res_i.final_res);
        end else begin
          want = peaks_due.pop_front();
          if (res_i.peak_index !== want.index || res_i.found !== want.found ||
              res_i.final_res !== want.last) begin
            errs++;
            if (errs <= MAX_REPORT)
              $display("result mismatch: expected index %0d found %0b final %0b, got %0d %0b %0b",
                       want.index, want.found, want.last,
                       res_i.peak_index, res_i.found, res_i.final_res);
          end
        end
      end
      if (smp_i.valid && smp_i.ready) take_sample(smp_i.sample_value, smp_i.record_end);
      if (cfg_we_i) hw_q = cfg_wdata_i;
      err_cnt_o <= errs;
      pending_o <= peaks_due.size();
    end
  end

endmodule

### test/windowed_peak_finder_tb.sv
`timescale 1ns / 100ps
// Testbench top for windowed_peak_finder: clock, reset, sample and register stimulus,
// result back-pressure and the verdict. Depends on wpf_pkg, the channel interfaces,
// the block and windowed_peak_finder_chk.
module windowed_peak_finder_tb;

  localparam int LIMIT       = 200000;
  localparam int HOLD_CYCLES = 80;
  localparam int IDLE_PCT    = 11;
  localparam int ITEM_TARGET = 510;

  localparam int KIND_FULL    = 0;
  localparam int KIND_TIES    = 1;
  localparam int KIND_EXTREME = 2;
  localparam int KIND_MIXED   = 3;

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         cfg_we;
  logic [wpf_pkg::CFG_BITS-1:0] cfg_wdata;
  int                           err_cnt;
  int                           pending;
  int                           sent_items;
  int                           hold_tag;
  int                           cycle_cnt;
  bit                           src_idle_en;
  bit                           snk_idle_en;

  wpf_in_if  smp_if ();
  wpf_out_if res_if ();

  windowed_peak_finder u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .smp_i       (smp_if),
    .res_o       (res_if)
  );

  windowed_peak_finder_chk u_chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .smp_i       (smp_if),
    .res_i       (res_if),
    .err_cnt_o   (err_cnt),
    .pending_o   (pending)
  );

  always #2 clk_i = ~clk_i;

  initial begin : watchdog
    cycle_cnt = 0;
    while (cycle_cnt < LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : result_sink
    int seen_tag;
    int hold_left;
    seen_tag = 0;
    hold_left = 0;
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_tag != seen_tag) begin
        seen_tag  = hold_tag;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= !(snk_idle_en && $urandom_range(99) < IDLE_PCT);
      end
    end
  end

  function automatic logic signed [wpf_pkg::SAMPLE_BITS-1:0] rand_sample(int kind);
    logic signed [wpf_pkg::SAMPLE_BITS-1:0] s;
    int                                     k;
    k = (kind == KIND_MIXED) ? $urandom_range(KIND_EXTREME) : kind;
    case (k)
      KIND_TIES: begin
        s = wpf_pkg::SAMPLE_BITS'($urandom_range(6));
        s = s - wpf_pkg::SAMPLE_BITS'(3);
      end
      KIND_EXTREME: begin
        case ($urandom_range(3))
          0: s = {1'b1, {(wpf_pkg::SAMPLE_BITS-1){1'b0}}};
          1: s = {1'b0, {(wpf_pkg::SAMPLE_BITS-1){1'b1}}};
          2: s = '0;
          default: s = '1;
        endcase
      end
      default: s = wpf_pkg::SAMPLE_BITS'($urandom());
    endcase
    return s;
  endfunction

  task automatic send_sample(logic signed [wpf_pkg::SAMPLE_BITS-1:0] v, logic last);
    while (src_idle_en && $urandom_range(99) < IDLE_PCT) begin
      smp_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    smp_if.valid        <= 1'b1;
    smp_if.sample_value <= v;
    smp_if.record_end   <= last;
    do @(posedge clk_i); while (!smp_if.ready);
    sent_items++;
  endtask

  task automatic send_record(int kind);
    int len;
    len = ($urandom_range(7) == 0) ? $urandom_range(25, 100) : $urandom_range(1, 24);
    for (int i = 0; i < len; i++) send_sample(rand_sample(kind), i == len - 1);
  endtask

  // drop valid, then hold until every predicted result has been taken
  task automatic wait_drained();
    smp_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_half_width(logic [wpf_pkg::CFG_BITS-1:0] v);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  initial begin : stimulus
    int phase_end;
    rst_ni              = 1'b0;
    cfg_we              = 1'b0;
    cfg_wdata           = '0;
    smp_if.valid        = 1'b0;
    smp_if.sample_value = '0;
    smp_if.record_end   = 1'b0;
    src_idle_en         = 1'b1;
    snk_idle_en         = 1'b1;
    hold_tag            = 0;
    sent_items          = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // half_width at its reset value
    send_sample(16'sh7fff, 1'b1);
    send_sample(-16'sd32768, 1'b0);
    send_sample(16'sh7fff, 1'b0);
    send_sample(-16'sd32768, 1'b0);
    send_sample(16'sh7fff, 1'b1);
    send_sample(16'sd7, 1'b0);
    send_sample(16'sd7, 1'b0);
    send_sample(16'sd7, 1'b0);
    send_sample(16'sd7, 1'b1);
    send_sample(16'sd100, 1'b0);
    send_sample(16'sd50, 1'b0);
    send_sample(-16'sd100, 1'b1);

    // zero acts as one
    write_half_width(5'd0);
    send_sample(16'sd1, 1'b0);
    send_sample(16'sd2, 1'b0);
    send_sample(16'sd1, 1'b1);

    // widest window, record shorter than the window
    write_half_width(5'd31);
    send_sample(-16'sd5, 1'b0);
    send_sample(16'sd3, 1'b0);
    send_sample(16'sd9, 1'b0);
    send_sample(16'sd3, 1'b0);
    send_sample(-16'sd1, 1'b1);

    // change half_width in the middle of a record
    write_half_width(5'd2);
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd10, 1'b0);
    send_sample(16'sd0, 1'b0);
    write_half_width(5'd1);
    send_sample(16'sd4, 1'b0);
    send_sample(16'sd20, 1'b1);

    for (int ph = 0; sent_items < ITEM_TARGET; ph++) begin
      case (ph % 8)
        0: write_half_width(5'd1);
        1: write_half_width(5'd2);
        2: write_half_width(5'd3);
        3: write_half_width(5'd0);
        4: write_half_width(5'd5);
        5: write_half_width(5'd31);
        6: write_half_width(5'd8);
        default: write_half_width(wpf_pkg::CFG_BITS'($urandom_range(31)));
      endcase
      src_idle_en = (ph != 2);
      snk_idle_en = (ph != 2);
      // stall the result side while samples keep coming
      if (ph == 0) hold_tag <= hold_tag + 1;
      phase_end = sent_items + 70;
      while (sent_items < phase_end) send_record($urandom_range(KIND_MIXED, KIND_FULL));
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (err_cnt == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
